// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL; frcp_parse.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/frcp_pkg.sv =====
`default_nettype none

package frcp_pkg;

   // Characters that steer the parse.
   localparam logic [7:0] CHAR_LINE_FEED = 8'd10;
   localparam logic [7:0] CHAR_DASH      = 8'h2D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   // Line positions.
   localparam logic [2:0] POS_CODE_END = 3'd3;   // bytes in a reply code
   localparam logic [2:0] POS_SAT      = 3'd4;   // first-line saturation point
   localparam logic [2:0] POS_NO_CLOSE = 3'd5;   // later line that cannot close

   // Code limits.
   localparam logic [9:0] CODE_MIN      = 10'd100;
   localparam logic [9:0] CODE_FINAL_LO = 10'd200;

   // Register map, indexed by word address.
   localparam logic REG_DROP_PRELIM = 1'b0;

   typedef enum logic [1:0] {
      PHASE_FIRST = 2'b01,
      PHASE_LATER = 2'b10
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [9:0] code;
      logic       malformed;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

endpackage

`default_nettype wire

// ===== sv/frcp_parse.sv =====
`default_nettype none

module frcp_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [7:0]           reply_byte,
   input  wire logic                 drop_preliminary,
   output frcp_pkg::result_type      result
);

   frcp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          pos_ff, pos_in;
   logic [23:0]         code_ff, code_in;
   logic                bad_ff, bad_in;
   logic                multi_ff, multi_in;
   logic                close_ff, close_in;

   logic       restart;
   logic       good_done;
   logic [9:0] code_val;
   logic [7:0] want;
   logic       byte_digit;

   // Stored code bytes are digits whenever a good reply finishes, so the
   // low nibble of each byte is its digit value.
   assign code_val = 10'(code_ff[19:16]) * 10'd100
                   + 10'(code_ff[11:8]) * 10'd10
                   + 10'(code_ff[3:0]);

   assign byte_digit = frcp_pkg::is_digit(reply_byte);

   always_comb begin
      case (pos_ff)
         3'd0:    want = code_ff[23:16];
         3'd1:    want = code_ff[15:8];
         default: want = code_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      code_in   = code_ff;
      bad_in    = bad_ff;
      multi_in  = multi_ff;
      close_in  = close_ff;
      restart   = 1'b0;
      good_done = 1'b0;
      result    = '0;

      if (step_en) begin
         case (phase_ff)
            frcp_pkg::PHASE_FIRST: begin
               if (reply_byte == frcp_pkg::CHAR_LINE_FEED) begin
                  if ((pos_ff < frcp_pkg::POS_CODE_END) || bad_ff) begin
                     restart          = 1'b1;
                     result.valid     = 1'b1;
                     result.malformed = 1'b1;
                  end else if (multi_ff) begin
                     phase_in = frcp_pkg::PHASE_LATER;
                     pos_in   = '0;
                     close_in = 1'b0;
                  end else begin
                     good_done = 1'b1;
                  end
               end else begin
                  if (pos_ff < frcp_pkg::POS_CODE_END) begin
                     if (!byte_digit ||
                         ((pos_ff == 3'd0) && (reply_byte == frcp_pkg::CHAR_ZERO))) begin
                        bad_in = 1'b1;
                     end
                     code_in = {code_ff[15:0], reply_byte};
                  end else if (pos_ff == frcp_pkg::POS_CODE_END) begin
                     if (byte_digit) begin
                        bad_in = 1'b1;
                     end else if (reply_byte == frcp_pkg::CHAR_DASH) begin
                        multi_in = 1'b1;
                     end
                  end
                  if (pos_ff < frcp_pkg::POS_SAT) begin
                     pos_in = pos_ff + 3'd1;
                  end
               end
            end
            default: begin
               if (reply_byte == frcp_pkg::CHAR_LINE_FEED) begin
                  if (close_ff) begin
                     good_done = 1'b1;
                  end else begin
                     pos_in   = '0;
                     close_in = 1'b0;
                  end
               end else if (pos_ff < frcp_pkg::POS_CODE_END) begin
                  pos_in = (reply_byte == want) ? pos_ff + 3'd1 : frcp_pkg::POS_NO_CLOSE;
               end else if (pos_ff == frcp_pkg::POS_CODE_END) begin
                  if (reply_byte == frcp_pkg::CHAR_SPACE) begin
                     close_in = 1'b1;
                     pos_in   = frcp_pkg::POS_SAT;
                  end else begin
                     pos_in = frcp_pkg::POS_NO_CLOSE;
                  end
               end
            end
         endcase

         if (good_done) begin
            restart = 1'b1;
            if (!(drop_preliminary && (code_val >= frcp_pkg::CODE_MIN) &&
                  (code_val < frcp_pkg::CODE_FINAL_LO))) begin
               result.valid = 1'b1;
               result.code  = code_val;
            end
         end

         if (restart) begin
            phase_in = frcp_pkg::PHASE_FIRST;
            pos_in   = '0;
            code_in  = '0;
            bad_in   = 1'b0;
            multi_in = 1'b0;
            close_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= frcp_pkg::PHASE_FIRST;
         pos_ff   <= '0;
         code_ff  <= '0;
         bad_ff   <= 1'b0;
         multi_ff <= 1'b0;
         close_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         code_ff  <= code_in;
         bad_ff   <= bad_in;
         multi_ff <= multi_in;
         close_ff <= close_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_AT(a_bad_code_zero, clock, reset, (result.valid && result.malformed) |-> (result.code == '0), "malformed result with nonzero code")
   `ASSERT_AT(a_good_code_range, clock, reset, (result.valid && !result.malformed) |-> ((result.code >= frcp_pkg::CODE_MIN) && (result.code <= 10'd999)), "good result code out of range")
   `ASSERT_NEVER(a_pos_range, clock, reset, pos_ff > frcp_pkg::POS_NO_CLOSE, "line position beyond no-close mark")
   `ASSERT_AT(a_later_is_clean, clock, reset, (phase_ff == frcp_pkg::PHASE_LATER) |-> (multi_ff && !bad_ff), "later line without a good multi-line first line")

endmodule

`default_nettype wire

// ===== sv/frcp_out_reg.sv =====
`default_nettype none

module frcp_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire frcp_pkg::result_type result,
   output logic                      can_load,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic                      rsp_tuser
);

   logic       valid_ff, valid_in;
   logic [9:0] code_ff;
   logic       bad_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= result.code;
         bad_ff  <= result.malformed;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, code_ff};
   assign rsp_tuser  = bad_ff;

endmodule

`default_nettype wire

// ===== sv/ftp_reply_code_parser_top.sv =====
// Channel   Direction  Payload
// req_      in         tdata[7:0] = reply_byte
// rsp_      out        tdata[9:0] = reply_code, tuser = malformed
// csr_      in (APB)   word 0 bit 0 = drop_preliminary
//
// Each byte is held in the input register and is parsed the cycle it leaves
// it; one byte per cycle is sustained while rsp_ is not back-pressured. A
// result is registered from the parse and can be taken at the next edge.
// Reset is synchronous and returns the parser to the start of a reply with
// drop_preliminary set. When the result register is full and not taken, the
// parser stalls and one more byte is still accepted into the input register.
`default_nettype none

module ftp_reply_code_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] reply_byte

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [9:0] reply_code, [15:10] zero
   output logic             rsp_tuser,    // [0] malformed

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Input register: holds one byte until the parser can take it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_fire;
   logic       step;
   logic       can_load;

   // The configuration register.
   logic drop_ff, drop_in;
   logic csr_write;

   frcp_pkg::result_type result;

   assign req_fire   = req_tvalid && req_tready;
   // A byte is parsed only when the result register has room, so a result
   // produced by it can always be stored.
   assign step       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Register write completes on the APB access cycle; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      drop_in = drop_ff;
      if (csr_write && (csr_paddr[2] == frcp_pkg::REG_DROP_PRELIM)) begin
         drop_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= 1'b1;
      end else begin
         drop_ff <= drop_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == frcp_pkg::REG_DROP_PRELIM) ? {31'd0, drop_ff} : '0;

   // Reply recognizer: state and per-byte next-state logic.
   frcp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step),
      .reply_byte       (in_byte_ff),
      .drop_preliminary (drop_ff),
      .result           (result)
   );

   // Result register on the rsp_ channel.
   frcp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && result.valid),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== bench/ftp_reply_code_parser_top_tb.sv =====
`timescale 1ns / 1ps

module ftp_reply_code_parser_top_tb;

   // One byte waiting to be sent. Directed rows may carry a hand-written
   // result that the bench expects at that byte instead of the predicted one.
   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      logic [9:0] code;
      logic       malformed;
   } stim_entry_type;

   typedef struct packed {
      logic [9:0] code;
      logic       malformed;
   } reply_result_type;

   localparam logic [2:0] DROP_PRELIM_ADDR = {frcp_pkg::REG_DROP_PRELIM, 2'b00};
   localparam logic [7:0] CHAR_CR          = 8'h0D;
   localparam logic [7:0] LF               = frcp_pkg::CHAR_LINE_FEED;
   localparam logic [7:0] DASH             = frcp_pkg::CHAR_DASH;
   localparam logic [7:0] SPACE            = frcp_pkg::CHAR_SPACE;
   localparam int         SETTLE_CYCLES    = 6;
   localparam int         STALL_LIMIT      = 2000;
   localparam int         BYTES_PER_PHASE  = 240;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] reply_byte

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [9:0] reply_code, [15:10] zero
   logic        rsp_tuser;           // [0] malformed

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ftp_reply_code_parser_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bytes still to be sent, and the reply results the block still owes us.
   stim_entry_type   byte_backlog[$];
   reply_result_type awaited_replies[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int fail_count = 0;
   int bytes_sent = 0;
   int replies_checked = 0;
   int malformed_checked = 0;

   // Directed part, sent with drop_preliminary at its reset value of 1.
   // Results are written in where they are obvious; the swallowed 1xx reply
   // relies on the predictor to expect nothing.
   stim_entry_type directed_rows [0:28] = '{
      // A line feed as the very first byte is a short first line.
      '{LF,  1'b1, 10'd0, 1'b1},
      // A leading zero is below 100; also sends the byte extremes.
      '{"0",   1'b0, 10'd0, 1'b0},
      '{8'hFF, 1'b0, 10'd0, 1'b0},
      '{8'h00, 1'b0, 10'd0, 1'b0},
      '{LF,    1'b1, 10'd0, 1'b1},
      // A digit in the fourth position is malformed.
      '{"1", 1'b0, 10'd0, 1'b0},
      '{"2", 1'b0, 10'd0, 1'b0},
      '{"3", 1'b0, 10'd0, 1'b0},
      '{"4", 1'b0, 10'd0, 1'b0},
      '{LF,  1'b1, 10'd0, 1'b1},
      // The lowest code, a preliminary reply, is swallowed.
      '{"1", 1'b0, 10'd0, 1'b0},
      '{"0", 1'b0, 10'd0, 1'b0},
      '{"0", 1'b0, 10'd0, 1'b0},
      '{LF,  1'b0, 10'd0, 1'b0},
      // A carriage return is an ordinary byte: single-line reply.
      '{"2",     1'b0, 10'd0,   1'b0},
      '{"2",     1'b0, 10'd0,   1'b0},
      '{"0",     1'b0, 10'd0,   1'b0},
      '{CHAR_CR, 1'b0, 10'd0,   1'b0},
      '{LF,      1'b1, 10'd220, 1'b0},
      // The highest code as a two-line reply.
      '{"9",   1'b0, 10'd0,   1'b0},
      '{"9",   1'b0, 10'd0,   1'b0},
      '{"9",   1'b0, 10'd0,   1'b0},
      '{DASH,  1'b0, 10'd0,   1'b0},
      '{LF,    1'b0, 10'd0,   1'b0},
      '{"9",   1'b0, 10'd0,   1'b0},
      '{"9",   1'b0, 10'd0,   1'b0},
      '{"9",   1'b0, 10'd0,   1'b0},
      '{SPACE, 1'b0, 10'd0,   1'b0},
      '{LF,    1'b1, 10'd999, 1'b0}
   };

   // ------------------------------------------------------------------
   // Reply predictor: the bench's own copy of the parse state.
   // ------------------------------------------------------------------
   frcp_pkg::phase_type scan_phase = frcp_pkg::PHASE_FIRST;
   logic [2:0]  scan_pos = 3'd0;
   logic [23:0] code_chars = 24'd0;
   logic        code_bad = 1'b0;
   logic        is_multi = 1'b0;
   logic        close_armed = 1'b0;
   logic        drop_prelim_cfg = 1'b1;

   function automatic logic is_decimal_char(input logic [7:0] ch);
      return (ch >= frcp_pkg::CHAR_ZERO) && (ch <= frcp_pkg::CHAR_NINE);
   endfunction

   task automatic restart_scan();
      scan_phase  = frcp_pkg::PHASE_FIRST;
      scan_pos    = 3'd0;
      code_chars  = 24'd0;
      code_bad    = 1'b0;
      is_multi    = 1'b0;
      close_armed = 1'b0;
   endtask

   // A well-formed reply has ended: report its code unless it is a
   // preliminary reply and those are being dropped.
   task automatic close_good_reply(output bit got, output reply_result_type res);
      int unsigned d0, d1, d2, value;
      d0 = 32'(code_chars[23:16]) - 32'(frcp_pkg::CHAR_ZERO);
      d1 = 32'(code_chars[15:8]) - 32'(frcp_pkg::CHAR_ZERO);
      d2 = 32'(code_chars[7:0]) - 32'(frcp_pkg::CHAR_ZERO);
      value = (d0 * 100 + d1 * 10 + d2) & 32'h3FF;
      restart_scan();
      got = 1'b0;
      res = '0;
      if (!(drop_prelim_cfg && value >= frcp_pkg::CODE_MIN &&
            value < frcp_pkg::CODE_FINAL_LO)) begin
         got = 1'b1;
         res.code = value[9:0];
      end
   endtask

   task automatic track_reply_byte(input logic [7:0] ch, output bit got,
                                   output reply_result_type res);
      logic [2:0] p;
      int         shift;
      p = scan_pos;
      got = 1'b0;
      res = '0;
      if (scan_phase == frcp_pkg::PHASE_FIRST) begin
         if (ch == LF) begin
            if (p < frcp_pkg::POS_CODE_END || code_bad) begin
               restart_scan();
               got = 1'b1;
               res.malformed = 1'b1;
            end else if (is_multi) begin
               scan_phase  = frcp_pkg::PHASE_LATER;
               scan_pos    = 3'd0;
               close_armed = 1'b0;
            end else begin
               close_good_reply(got, res);
            end
         end else begin
            if (p < frcp_pkg::POS_CODE_END) begin
               if (!is_decimal_char(ch) || (p == 0 && ch == frcp_pkg::CHAR_ZERO))
                  code_bad = 1'b1;
               code_chars = {code_chars[15:0], ch};
            end else if (p == frcp_pkg::POS_CODE_END) begin
               if (is_decimal_char(ch))
                  code_bad = 1'b1;
               else if (ch == DASH)
                  is_multi = 1'b1;
            end
            if (p < frcp_pkg::POS_SAT)
               scan_pos = p + 3'd1;
         end
      end else begin
         // Later lines: only one that repeats the code and a space closes.
         if (ch == LF) begin
            if (close_armed) begin
               close_good_reply(got, res);
            end else begin
               scan_pos    = 3'd0;
               close_armed = 1'b0;
            end
         end else if (p < frcp_pkg::POS_CODE_END) begin
            shift = 8 * (2 - int'(p));
            scan_pos = (ch == code_chars[shift +: 8]) ? p + 3'd1 : frcp_pkg::POS_NO_CLOSE;
         end else if (p == frcp_pkg::POS_CODE_END) begin
            if (ch == SPACE) begin
               close_armed = 1'b1;
               scan_pos    = frcp_pkg::POS_SAT;
            end else begin
               scan_pos = frcp_pkg::POS_NO_CLOSE;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sender: presents backlog bytes, predicts each one as it is taken.
   // ------------------------------------------------------------------
   stim_entry_type in_flight = '0;

   always @(posedge clock) begin : feed_bytes
      bit               got;
      reply_result_type res;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_sent++;
            track_reply_byte(in_flight.ch, got, res);
            if (in_flight.typed) begin
               if (!got) begin
                  fail_count++;
                  $display("%0t: directed row expected code %0d malformed %0b,",
                           $time, in_flight.code, in_flight.malformed,
                           " predicted none");
               end
               awaited_replies.push_back('{in_flight.code, in_flight.malformed});
            end else if (got) begin
               awaited_replies.push_back(res);
            end
         end
         // The slot is free when nothing is shown or the shown item was taken.
         if (!req_tvalid || req_tready) begin
            if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               in_flight = byte_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= in_flight.ch;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random back-pressure and in-order comparison.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : take_results
      reply_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_replies.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, got tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = awaited_replies.pop_front();
               replies_checked++;
               if (want.malformed)
                  malformed_checked++;
               if (rsp_tdata !== {6'd0, want.code} || rsp_tuser !== want.malformed) begin
                  fail_count++;
                  $display("%0t: reply mismatch: expected code %0d malformed %0b,",
                           $time, want.code, want.malformed,
                           " got tdata %h tuser %b", rsp_tdata, rsp_tuser);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Watchdog: a long run of cycles with no handshake on any port is a hang.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Random reply generator. Most replies are well formed so the later-line
   // states get exercised; the rest are broken first lines and raw noise.
   // ------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] ch);
      byte_backlog.push_back('{ch, 1'b0, 10'd0, 1'b0});
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch == LF);
      return ch;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] ch;
      do ch = text_char(); while (is_decimal_char(ch) || ch == DASH);
      return ch;
   endfunction

   task automatic add_text(input int max_len);
      repeat ($urandom_range(0, max_len)) add_byte(text_char());
   endtask

   task automatic add_random_reply();
      logic [7:0] code [3];
      int         roll, k;
      roll = $urandom_range(0, 99);
      // Preliminary codes are favored so dropping them is exercised often.
      code[0] = 8'(frcp_pkg::CHAR_ZERO +
                   (($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 9)));
      code[1] = 8'(frcp_pkg::CHAR_ZERO + $urandom_range(0, 9));
      code[2] = 8'(frcp_pkg::CHAR_ZERO + $urandom_range(0, 9));
      if (roll < 35) begin
         for (k = 0; k < 3; k++) add_byte(code[k]);
         case ($urandom_range(0, 3))
            0: begin
               add_byte(SPACE);
               add_text(6);
            end
            1: add_byte(CHAR_CR);
            2: ;
            default: begin
               add_byte(plain_char());
               add_text(6);
            end
         endcase
         add_byte(LF);
      end else if (roll < 70) begin
         for (k = 0; k < 3; k++) add_byte(code[k]);
         add_byte(DASH);
         add_text(6);
         add_byte(LF);
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 4))
               0: add_text(8);
               1: begin
                  // Same code but a dash: a continuation, not the end.
                  for (k = 0; k < 3; k++) add_byte(code[k]);
                  add_byte(DASH);
                  add_text(4);
               end
               2: begin
                  // Code prefix that breaks off part way.
                  for (k = 0; k < $urandom_range(0, 2); k++) add_byte(code[k]);
                  add_byte(code[k] ^ 8'h01);
                  add_text(4);
               end
               3: begin
                  for (k = 0; k < 3; k++) add_byte(code[k]);
                  add_byte(plain_char() | 8'h01);
                  add_text(4);
               end
               default: ;
            endcase
            add_byte(LF);
         end
         for (k = 0; k < 3; k++) add_byte(code[k]);
         add_byte(SPACE);
         add_text(4);
         add_byte(LF);
      end else if (roll < 85) begin
         case ($urandom_range(0, 4))
            0: for (k = 0; k < $urandom_range(0, 2); k++) add_byte(code[k]);
            1: begin
               add_byte(frcp_pkg::CHAR_ZERO);
               add_byte(code[1]);
               add_byte(code[2]);
               add_text(4);
            end
            2: begin
               for (k = 0; k < 3; k++) add_byte(code[k]);
               add_byte(8'(frcp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
               add_text(4);
            end
            3: begin
               k = $urandom_range(0, 2);
               code[k] = plain_char();
               for (k = 0; k < 3; k++) add_byte(code[k]);
               add_text(4);
            end
            default: begin
               // Malformed code with a dash: still one line only.
               add_byte(frcp_pkg::CHAR_ZERO);
               add_byte(code[1]);
               add_byte(code[2]);
               add_byte(DASH);
               add_text(4);
            end
         endcase
         add_byte(LF);
      end else begin
         repeat ($urandom_range(1, 6))
            add_byte(($urandom_range(0, 3) == 0) ? LF : 8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------
   // Control.
   // ------------------------------------------------------------------

   // APB write: setup cycle, then an access cycle that ends with pready.
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == DROP_PRELIM_ADDR)
         drop_prelim_cfg = data[0];
   endtask

   // Wait until every byte is in and every result is out,
   // then give a swallowed last reply time to clear the pipeline.
   task automatic drain_replies();
      while (byte_backlog.size() != 0 || req_tvalid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input logic drop, input int tx_pct, input int rx_pct);
      write_csr(DROP_PRELIM_ADDR, {31'($urandom()), drop});
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      while (byte_backlog.size() < BYTES_PER_PHASE) add_random_reply();
      drain_replies();
   endtask

   initial begin
      restart_scan();
      drop_prelim_cfg = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rows under the reset configuration.
      tx_idle_pct = 10;
      rx_idle_pct = 57;
      foreach (directed_rows[i]) byte_backlog.push_back(directed_rows[i]);
      drain_replies();

      // Random replies: both register settings and all three idle patterns.
      run_random_phase(1'b0, 10, 57);
      run_random_phase(1'b1, 57, 10);
      run_random_phase(1'b0, 0, 0);

      if (awaited_replies.size() != 0) begin
         fail_count++;
         $display("%0t: %0d results never arrived", $time, awaited_replies.size());
      end

      $display("Sent %0d reply bytes: directed edge cases, then random replies",
               bytes_sent, " with preliminary drop on and off.");
      $display("Checked %0d results, %0d of them malformed, %0d failures.",
               replies_checked, malformed_checked, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
